// ----- sv/lcg48_random_source_unit_assert.svh -----
// Assertion macros shared by the lcg48 random source modules.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef LCG48_RANDOM_SOURCE_UNIT_ASSERT_SVH
`define LCG48_RANDOM_SOURCE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCG48_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCG48_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lcg48_pkg.sv -----
// Shared types and constants for the lcg48 random source.
// No dependencies; used by lcg48_alu and lcg48_random_source_unit.
package lcg48_pkg;

  localparam int STATE_W   = 48;
  localparam int BOUND_W   = 31;
  localparam int VALUE_W   = 64;
  localparam int CNT_W     = 5;
  localparam int ADV_STEPS = 9;   // four multiplier bits per step
  localparam int MOD_STEPS = 31;  // one quotient bit per step

  localparam logic [35:0] LCG_MULT = 36'h5DEECE66D;
  localparam logic [3:0]  LCG_ADD  = 4'hB;

  typedef enum logic [2:0] {
    ACT_INT32   = 3'd0,
    ACT_BOUNDED = 3'd1,
    ACT_BOOL    = 3'd2,
    ACT_LONG    = 3'd3,
    ACT_UNIT24  = 3'd4,
    ACT_UNIT53  = 3'd5
  } act_t;

  typedef enum logic {
    ALU_ADVANCE = 1'b0,
    ALU_MOD     = 1'b1
  } alu_op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_ADV  = 2'd1,
    S_MOD  = 2'd2,
    S_FIN  = 2'd3
  } fsm_t;

  typedef struct packed {
    logic                 start;
    alu_op_t              op;
    logic [STATE_W-1:0]   state;
    logic [BOUND_W-1:0]   num;
    logic [BOUND_W-1:0]   den;
  } alu_cmd_t;

  typedef struct packed {
    logic               done;
    logic [STATE_W-1:0] value;
  } alu_rsp_t;

endpackage

// ----- sv/lcg48_alu.sv -----
// Iterative arithmetic unit: LCG state advance by shift-and-add and 31-bit remainder
// by restoring division, both on one shared 49-bit adder. Depends on lcg48_pkg.
`include "lcg48_random_source_unit_assert.svh"

module lcg48_alu import lcg48_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_cmd_t cmd,
  output alu_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  alu_op_t              op_r, op_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [STATE_W-1:0]   acc_r, acc_nxt;
  logic [STATE_W-1:0]   mcand_r, mcand_nxt;
  logic [BOUND_W-1:0]   dvd_r, dvd_nxt;
  logic [BOUND_W-1:0]   den_r, den_nxt;

  logic [3:0]           digit;
  logic [STATE_W+3:0]   partial;
  logic [31:0]          shifted;
  logic [STATE_W:0]     add_a, add_b, add_sum;
  logic                 add_cin;
  logic                 last;

  always_comb begin
    digit   = LCG_MULT[{cnt_r[3:0], 2'b00} +: 4];
    partial = (STATE_W+4)'(mcand_r) * (STATE_W+4)'(digit);
    shifted = {acc_r[30:0], dvd_r[BOUND_W-1]};

    // Accumulate for the advance, trial subtract of the divisor for the remainder.
    if (op_r == ALU_ADVANCE) begin
      add_a   = {1'b0, acc_r};
      add_b   = {1'b0, partial[STATE_W-1:0]};
      add_cin = 1'b0;
    end else begin
      add_a   = {17'b0, shifted};
      add_b   = ~{18'b0, den_r};
      add_cin = 1'b1;
    end
    add_sum = add_a + add_b + (STATE_W+1)'(add_cin);

    if (op_r == ALU_ADVANCE) begin
      last = (cnt_r == CNT_W'(ADV_STEPS - 1));
    end else begin
      last = (cnt_r == CNT_W'(MOD_STEPS - 1));
    end

    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    dvd_nxt   = dvd_r;
    den_nxt   = den_r;

    if (busy_r) begin
      if (op_r == ALU_ADVANCE) begin
        acc_nxt   = add_sum[STATE_W-1:0];
        mcand_nxt = {mcand_r[STATE_W-5:0], 4'b0};
      end else begin
        // A set sign bit means the trial subtract went negative: keep the shifted value.
        acc_nxt = add_sum[STATE_W] ? {16'b0, shifted} : add_sum[STATE_W-1:0];
        dvd_nxt = {dvd_r[BOUND_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (cmd.start) begin
      busy_nxt  = 1'b1;
      op_nxt    = cmd.op;
      cnt_nxt   = '0;
      acc_nxt   = (cmd.op == ALU_ADVANCE) ? STATE_W'(LCG_ADD) : '0;
      mcand_nxt = cmd.state;
      dvd_nxt   = cmd.num;
      den_nxt   = cmd.den;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= ALU_ADVANCE;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    dvd_r   <= dvd_nxt;
    den_r   <= den_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.value = acc_r;

  `LCG48_ASSERT_IMP(a_start_when_free, cmd.start, !busy_r, "start while busy")
  `LCG48_ASSERT_NXT(a_done_single, done_r, !done_r, "done held for two cycles")
  `LCG48_ASSERT_IMP(a_adv_count, busy_r && (op_r == ALU_ADVANCE),
                    cnt_r < CNT_W'(ADV_STEPS), "advance ran past its last step")

endmodule

// ----- sv/lcg48_random_source_unit.sv -----
// From input transaction to out_tvalid, actions 0, 2 and 4 and power-of-two bounds take one
// state advance; actions 3 and 5 take two; other bounds take an advance and a remainder,
// repeated for each rejected draw; unused actions take neither. In the shared unit an advance
// goes four multiplier bits a cycle, a remainder one quotient bit a cycle. The next input
// is taken in the cycle after the result enters the output register. Synchronous reset
// clears the generator state to zero and all control state; there is no clearing pass.
`include "lcg48_random_source_unit_assert.svh"

module lcg48_random_source_unit import lcg48_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,   // [30:0] bound
  input  logic [2:0]          in_tuser,   // [2:0] action
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [VALUE_W-1:0]  out_tdata,  // [63:0] value
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [STATE_W-1:0]  cfg_data
);

  fsm_t                 st_r, st_nxt;
  act_t                 act_r, act_nxt;
  logic                 second_r, second_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BOUND_W-1:0]   bound_r, bound_nxt;
  logic [STATE_W-1:0]   gen_r, gen_nxt;
  logic [BOUND_W-1:0]   draw_r, draw_nxt;
  logic [31:0]          hi_r, hi_nxt;
  logic [VALUE_W-1:0]   res_r, res_nxt;
  logic [VALUE_W-1:0]   out_data_r, out_data_nxt;

  alu_cmd_t             cmd;
  alu_rsp_t             rsp;

  logic [STATE_W-1:0]   ns;
  logic                 pow2;
  logic [61:0]          pow_prod;
  logic [BOUND_W-1:0]   rem;
  logic [31:0]          chk;
  logic [31:0]          long_hi;

  lcg48_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rsp   (rsp)
  );

  always_comb begin
    ns       = rsp.value;
    pow2     = ((bound_r & (bound_r - BOUND_W'(1))) == '0);
    pow_prod = 62'(bound_r) * 62'(ns[47:17]);
    rem      = rsp.value[BOUND_W-1:0];
    // Rejection test: r - (r mod n) + (n - 1) must not wrap negative as a 32-bit word.
    chk      = {1'b0, draw_r} - {1'b0, rem} + {1'b0, bound_r} - 32'd1;
    // Adding a sign-extended low word borrows one from the high word when it is negative.
    long_hi  = hi_r + {32{ns[47]}};

    st_nxt        = st_r;
    act_nxt       = act_r;
    second_nxt    = second_r;
    bound_nxt     = bound_r;
    gen_nxt       = gen_r;
    draw_nxt      = draw_r;
    hi_nxt        = hi_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_tready;

    cmd.start = 1'b0;
    cmd.op    = ALU_ADVANCE;
    cmd.state = gen_r;
    cmd.num   = ns[47:17];
    cmd.den   = bound_r;

    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt    = act_t'(in_tuser);
          bound_nxt  = in_tdata[BOUND_W-1:0];
          second_nxt = 1'b0;
          if (in_tuser <= ACT_UNIT53) begin
            cmd.start = 1'b1;
            st_nxt    = S_ADV;
          end else begin
            res_nxt = '0;
            st_nxt  = S_FIN;
          end
        end
      end
      S_ADV: begin
        if (rsp.done) begin
          gen_nxt   = ns;
          cmd.state = ns;
          case (act_r)
            ACT_INT32: begin
              res_nxt = {{32{ns[47]}}, ns[47:16]};
              st_nxt  = S_FIN;
            end
            ACT_BOOL: begin
              res_nxt = VALUE_W'(ns[47]);
              st_nxt  = S_FIN;
            end
            ACT_UNIT24: begin
              res_nxt = VALUE_W'(ns[47:24]);
              st_nxt  = S_FIN;
            end
            ACT_LONG: begin
              if (!second_r) begin
                hi_nxt     = ns[47:16];
                second_nxt = 1'b1;
                cmd.start  = 1'b1;
              end else begin
                res_nxt = {long_hi, ns[47:16]};
                st_nxt  = S_FIN;
              end
            end
            ACT_UNIT53: begin
              if (!second_r) begin
                hi_nxt     = {6'b0, ns[47:22]};
                second_nxt = 1'b1;
                cmd.start  = 1'b1;
              end else begin
                res_nxt = {11'b0, hi_r[25:0], ns[47:21]};
                st_nxt  = S_FIN;
              end
            end
            ACT_BOUNDED: begin
              draw_nxt = ns[47:17];
              if (pow2) begin
                res_nxt = VALUE_W'(pow_prod[61:31]);
                st_nxt  = S_FIN;
              end else begin
                cmd.start = 1'b1;
                cmd.op    = ALU_MOD;
                st_nxt    = S_MOD;
              end
            end
            default: begin
              res_nxt = '0;
              st_nxt  = S_FIN;
            end
          endcase
        end
      end
      S_MOD: begin
        if (rsp.done) begin
          if (!chk[31]) begin
            res_nxt = VALUE_W'(rem);
            st_nxt  = S_FIN;
          end else begin
            cmd.start = 1'b1;
            st_nxt    = S_ADV;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    // Seed writes must arrive only while the block is idle; the block itself does not enforce this.
    if (cfg_valid) begin
      gen_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      act_r       <= ACT_INT32;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
      gen_r       <= '0;
    end else begin
      st_r        <= st_nxt;
      act_r       <= act_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
      gen_r       <= gen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bound_r    <= bound_nxt;
    draw_r     <= draw_nxt;
    hi_r       <= hi_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  `LCG48_ASSERT_IMP(a_done_in_wait, rsp.done, (st_r == S_ADV) || (st_r == S_MOD),
                    "unit finished outside a wait state")
  `LCG48_ASSERT_IMP(a_mod_bounded, st_r == S_MOD, act_r == ACT_BOUNDED,
                    "remainder pass for a non-bounded action")
  `LCG48_ASSERT_IMP(a_second_draw, second_r, (act_r == ACT_LONG) || (act_r == ACT_UNIT53),
                    "second draw for a single-draw action")

endmodule
